@@ rtl/gfpd_pkg.sv @@
package gfpd_pkg;

  localparam logic [1:0] CMD_LOAD_DIVIDEND = 2'd0;
  localparam logic [1:0] CMD_LOAD_DIVISOR  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE       = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_DIV_ZERO = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic WHICH_REM  = 1'b0;
  localparam logic WHICH_QUOT = 1'b1;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] coefficient;
  } in_beat_t;

  typedef struct packed {
    logic       which_poly;
    logic [4:0] degree_index;
    logic [7:0] coeff_out;
    logic [1:0] status;
    logic       last;
  } out_beat_t;

endpackage

@@ rtl/gfpd_mul.sv @@
// GF(2^8) multiplier, reduced by x^8 + poly.
module gfpd_mul (
  input  logic [7:0] a,
  input  logic [7:0] b,
  input  logic [7:0] poly,
  output logic [7:0] p
);

  always_comb begin
    logic [7:0] x;
    logic [7:0] r;
    x = a;
    r = 8'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x;
      x = x[7] ? ({x[6:0], 1'b0} ^ poly) : {x[6:0], 1'b0};
    end
    p = r;
  end

endmodule

@@ rtl/gf256_poly_divide_unit.sv @@
// GF(2^8) polynomial divider.
// Input channel (in_valid/in_ready/in_data): command 0 appends a dividend
// coefficient, 1 a divisor coefficient (lowest degree first), 2 computes.
// Loads are written straight into the stores while idle, back to back. A
// compute walks the stores with one shared GF multiplier: it leaves idle,
// trims dividend and divisor (reading each top, dropping zeros), picks the
// case (divide by zero gives only one zero remainder beat), inverts the
// divisor lead (square-and-multiply), then per quotient digit reads the top
// and multiplies it by the inverse, then updates each term under the divisor,
// and trims remainder and quotient. Results leave on out_valid/out_ready/
// out_data: remainder then quotient, lowest degree first, last set on the
// final beat. in_ready is low from the compute until the last beat is loaded
// into the output register; a stalled receiver simply holds the output
// register and the sequencer waits. cfg_we/cfg_data write the low byte of
// the field polynomial and may be used only while the block is idle.
// Reset (rst_n, synchronous) clears lengths, overflow and the sequencer and
// sets the field polynomial to 0x1b; the coefficient stores are not cleared.
module gf256_poly_divide_unit #(
  parameter int MAX_TERMS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gfpd_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gfpd_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data
);

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int LW = $clog2(MAX_TERMS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TRIMN = 4'd1;
  localparam logic [3:0] S_TRIMM = 4'd2;
  localparam logic [3:0] S_CASE  = 4'd3;
  localparam logic [3:0] S_INV   = 4'd4;
  localparam logic [3:0] S_QRD   = 4'd5;
  localparam logic [3:0] S_QMUL  = 4'd6;
  localparam logic [3:0] S_UPD   = 4'd7;
  localparam logic [3:0] S_RTRIM = 4'd8;
  localparam logic [3:0] S_QTRIM = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;
  localparam logic [3:0] S_WAIT  = 4'd11;

  localparam logic [1:0] MODE_DIV  = 2'd0;
  localparam logic [1:0] MODE_ZERO = 2'd1;
  localparam logic [1:0] MODE_DVD  = 2'd2;

  // stores
  logic [7:0] dvd_mem [MAX_TERMS];
  logic [7:0] dvs_mem [MAX_TERMS];
  logic [7:0] quo_mem [MAX_TERMS];

  logic [3:0]    state_r, state_nxt;
  logic [7:0]    poly_r;
  logic [LW-1:0] n_r, n_nxt, m_r, m_nxt;
  logic          ovf_r, ovf_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [LW-1:0] k_r, k_nxt;   // current top+1 of partial remainder
  logic [LW-1:0] j_r, j_nxt;   // inner index
  logic [4:0]    e_r, e_nxt;   // inverse step count
  logic [7:0]    inv_r, inv_nxt, base_r, base_nxt, t_r, t_nxt;
  logic [7:0]    lead_r, lead_nxt;
  logic [LW-1:0] rlen_r, rlen_nxt, qlen_r, qlen_nxt;
  logic          which_r, which_nxt;
  logic [1:0]    mode_r, mode_nxt; // normal, zero results, dividend as rem
  logic          out_valid_r, out_valid_nxt;
  gfpd_pkg::out_beat_t out_r, out_nxt;

  // memory port control
  logic          dvd_we, dvs_we, quo_we;
  logic [AW-1:0] dvd_wa, dvs_wa, quo_wa, dvd_ra, dvs_ra, quo_ra;
  logic [7:0]    dvd_wd, dvs_wd, quo_wd;
  logic [7:0]    dvd_q, dvs_q, quo_q;

  always_ff @(posedge clk) begin
    if (dvd_we) dvd_mem[dvd_wa] <= dvd_wd;
    if (dvs_we) dvs_mem[dvs_wa] <= dvs_wd;
    if (quo_we) quo_mem[quo_wa] <= quo_wd;
    dvd_q <= dvd_mem[dvd_ra];
    dvs_q <= dvs_mem[dvs_ra];
    quo_q <= quo_mem[quo_ra];
  end

  // shared multiplier
  logic [7:0] mul_a, mul_b, mul_p;
  gfpd_mul u_mul (.a(mul_a), .b(mul_b), .poly(poly_r), .p(mul_p));

  // pipeline tag: a read was issued last cycle
  logic rd_r, rd_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt = state_r;
    n_nxt = n_r; m_nxt = m_r; ovf_nxt = ovf_r; st_nxt = st_r;
    k_nxt = k_r; j_nxt = j_r; e_nxt = e_r;
    inv_nxt = inv_r; base_nxt = base_r; t_nxt = t_r; lead_nxt = lead_r;
    rlen_nxt = rlen_r; qlen_nxt = qlen_r; which_nxt = which_r; mode_nxt = mode_r;
    out_valid_nxt = out_valid_r; out_nxt = out_r; rd_nxt = 1'b0;
    dvd_we = 1'b0; dvs_we = 1'b0; quo_we = 1'b0;
    dvd_wa = '0; dvs_wa = '0; quo_wa = '0;
    dvd_wd = in_data.coefficient; dvs_wd = in_data.coefficient; quo_wd = t_r;
    dvd_ra = '0; dvs_ra = '0; quo_ra = '0;
    mul_a = inv_r; mul_b = base_r;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.command)
            gfpd_pkg::CMD_LOAD_DIVIDEND: begin
              if (n_r < LW'(MAX_TERMS)) begin
                dvd_we = 1'b1; dvd_wa = n_r[AW-1:0]; n_nxt = n_r + 1'b1;
              end else ovf_nxt = 1'b1;
            end
            gfpd_pkg::CMD_LOAD_DIVISOR: begin
              if (m_r < LW'(MAX_TERMS)) begin
                dvs_we = 1'b1; dvs_wa = m_r[AW-1:0]; m_nxt = m_r + 1'b1;
              end else ovf_nxt = 1'b1;
            end
            gfpd_pkg::CMD_COMPUTE: begin
              st_nxt = ovf_r ? gfpd_pkg::STATUS_OVERFLOW : gfpd_pkg::STATUS_OK;
              state_nxt = S_TRIMN;
            end
            default: ;
          endcase
        end
      end
      // trim dividend: read top, drop while zero
      S_TRIMN: begin
        if (n_r == '0) state_nxt = S_TRIMM;
        else if (!rd_r) begin
          dvd_ra = AW'(n_r - 1'b1); rd_nxt = 1'b1;
        end else if (dvd_q == 8'd0) n_nxt = n_r - 1'b1;
        else state_nxt = S_TRIMM;
      end
      S_TRIMM: begin
        if (m_r == '0) state_nxt = S_CASE;
        else if (!rd_r) begin
          dvs_ra = AW'(m_r - 1'b1); rd_nxt = 1'b1;
        end else if (dvs_q == 8'd0) m_nxt = m_r - 1'b1;
        else begin
          lead_nxt = dvs_q; state_nxt = S_CASE;
        end
      end
      S_CASE: begin
        which_nxt = gfpd_pkg::WHICH_REM; j_nxt = '0;
        if (n_r == '0) begin
          mode_nxt = MODE_ZERO; rlen_nxt = '0; qlen_nxt = '0; state_nxt = S_EMIT;
        end else if (m_r == '0) begin
          st_nxt = gfpd_pkg::STATUS_DIV_ZERO; mode_nxt = MODE_ZERO; state_nxt = S_EMIT;
        end else if (m_r > n_r) begin
          mode_nxt = MODE_DVD; rlen_nxt = n_r; qlen_nxt = '0; state_nxt = S_EMIT;
        end else begin
          mode_nxt = MODE_DIV; inv_nxt = 8'd1; base_nxt = lead_r; e_nxt = '0;
          k_nxt = n_r; state_nxt = S_INV;
        end
      end
      // lead^254: bits of 254 lsb first; even steps multiply, odd steps square
      S_INV: begin
        if (!e_r[0]) begin
          mul_a = inv_r; mul_b = base_r;
          if (e_r[4:1] != 4'd0) inv_nxt = mul_p; // bit0 of 254 is 0
        end else begin
          mul_a = base_r; mul_b = base_r; base_nxt = mul_p;
        end
        e_nxt = e_r + 1'b1;
        if (e_r == 5'd15) state_nxt = S_QRD;
      end
      // read current top of partial remainder (kept in dividend store)
      S_QRD: begin
        dvd_ra = AW'(k_r - 1'b1); state_nxt = S_QMUL;
      end
      S_QMUL: begin
        mul_a = dvd_q; mul_b = inv_r; t_nxt = mul_p;
        quo_we = 1'b1; quo_wa = AW'(k_r - m_r); quo_wd = mul_p;
        j_nxt = '0; state_nxt = S_UPD;
      end
      // per j: read rem[qi+j] and div[j], then write back xor product
      S_UPD: begin
        if (!rd_r) begin
          dvd_ra = AW'(k_r - m_r + j_r); dvs_ra = AW'(j_r); rd_nxt = 1'b1;
        end else begin
          mul_a = t_r; mul_b = dvs_q;
          dvd_we = 1'b1; dvd_wa = AW'(k_r - m_r + j_r);
          dvd_wd = (j_r == m_r - 1'b1) ? 8'd0 : (dvd_q ^ mul_p);
          if (j_r == m_r - 1'b1) begin
            if (k_r == m_r) begin
              rlen_nxt = m_r - 1'b1; qlen_nxt = n_r - m_r + 1'b1;
              j_nxt = '0; state_nxt = S_RTRIM;
            end else begin
              k_nxt = k_r - 1'b1; state_nxt = S_QRD;
            end
          end else j_nxt = j_r + 1'b1;
        end
      end
      S_RTRIM: begin
        if (rlen_r == '0) state_nxt = S_QTRIM;
        else if (!rd_r) begin
          dvd_ra = AW'(rlen_r - 1'b1); rd_nxt = 1'b1;
        end else if (dvd_q == 8'd0) rlen_nxt = rlen_r - 1'b1;
        else state_nxt = S_QTRIM;
      end
      S_QTRIM: begin
        if (qlen_r == '0) state_nxt = S_EMIT;
        else if (!rd_r) begin
          quo_ra = AW'(qlen_r - 1'b1); rd_nxt = 1'b1;
        end else if (quo_q == 8'd0) qlen_nxt = qlen_r - 1'b1;
        else state_nxt = S_EMIT;
      end
      // issue read of next coefficient for output
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          dvd_ra = AW'(j_r); quo_ra = AW'(j_r);
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        logic [LW-1:0] len;
        logic [7:0]    c;
        logic          fin;
        len = which_r ? qlen_r : rlen_r;
        c = (len == '0 || mode_r == MODE_ZERO) ? 8'd0 : (which_r ? quo_q : dvd_q);
        fin = (mode_r == MODE_ZERO && st_r == gfpd_pkg::STATUS_DIV_ZERO) ||
              (which_r && (len == '0 || j_r == len - 1'b1));
        out_valid_nxt = 1'b1;
        out_nxt.which_poly   = which_r;
        out_nxt.degree_index = 5'(j_r);
        out_nxt.coeff_out    = c;
        out_nxt.status       = st_r;
        out_nxt.last         = fin;
        if (fin) begin
          n_nxt = '0; m_nxt = '0; ovf_nxt = 1'b0; state_nxt = S_IDLE;
        end else if (len == '0 || mode_r == MODE_ZERO || j_r == len - 1'b1) begin
          which_nxt = gfpd_pkg::WHICH_QUOT; j_nxt = '0; state_nxt = S_EMIT;
        end else begin
          j_nxt = j_r + 1'b1; state_nxt = S_EMIT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; poly_r <= 8'd27; n_r <= '0; m_r <= '0;
      ovf_r <= 1'b0; out_valid_r <= 1'b0; rd_r <= 1'b0;
    end else begin
      state_r <= state_nxt; n_r <= n_nxt; m_r <= m_nxt; ovf_r <= ovf_nxt;
      out_valid_r <= out_valid_nxt; rd_r <= rd_nxt;
      if (cfg_we) poly_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt; k_r <= k_nxt; j_r <= j_nxt; e_r <= e_nxt;
    inv_r <= inv_nxt; base_r <= base_nxt; t_r <= t_nxt; lead_r <= lead_nxt;
    rlen_r <= rlen_nxt; qlen_r <= qlen_nxt; which_r <= which_nxt;
    mode_r <= mode_nxt; out_r <= out_nxt;
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int TERMS = 32;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 500;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  gfpd_pkg::in_beat_t in_data;
  logic out_valid;
  logic out_ready;
  gfpd_pkg::out_beat_t out_data;
  logic cfg_we;
  logic [7:0] cfg_data;

  gf256_poly_divide_unit #(.MAX_TERMS(TERMS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // predictor state
  logic [7:0] field_low;
  logic [7:0] num_coef [TERMS];
  logic [7:0] den_coef [TERMS];
  int num_len, den_len;
  logic ovf;

  gfpd_pkg::in_beat_t pending_beats[$];
  gfpd_pkg::out_beat_t expected_beats[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct, recv_idle_pct;
  int recv_hold;
  int hold_reqs = 0;
  int hold_seen;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= x;
      x = x[7] ? ((x << 1) ^ field_low) : (x << 1);
    end
    return r;
  endfunction

  function automatic logic [7:0] gf_inv(logic [7:0] b);
    logic [7:0] r;
    logic [7:0] base;
    r = 8'h01;
    base = b;
    for (int e = 254; e != 0; e >>= 1) begin
      if (e & 1) r = gf_mul(r, base);
      base = gf_mul(base, base);
    end
    return r;
  endfunction

  function automatic void add_coef(logic which, int deg, logic [7:0] c, logic [1:0] st);
    gfpd_pkg::out_beat_t b;
    b.which_poly = which;
    b.degree_index = deg[4:0];
    b.coeff_out = c;
    b.status = st;
    b.last = 1'b0;
    expected_beats = {expected_beats, b};
  endfunction

  // predict the results of one accepted input beat
  function automatic void predict_division(gfpd_pkg::in_beat_t beat);
    logic [7:0] rem [TERMS];
    logic [7:0] quo [TERMS];
    logic [7:0] inv, t;
    logic [1:0] st;
    int n, m, rl, ql;
    if (beat.command == gfpd_pkg::CMD_LOAD_DIVIDEND ||
        beat.command == gfpd_pkg::CMD_LOAD_DIVISOR) begin
      if (beat.command == gfpd_pkg::CMD_LOAD_DIVIDEND) begin
        if (num_len < TERMS) begin
          num_coef[num_len] = beat.coefficient;
          num_len++;
        end else ovf = 1'b1;
      end else begin
        if (den_len < TERMS) begin
          den_coef[den_len] = beat.coefficient;
          den_len++;
        end else ovf = 1'b1;
      end
      return;
    end
    if (beat.command != gfpd_pkg::CMD_COMPUTE) return;
    st = ovf ? gfpd_pkg::STATUS_OVERFLOW : gfpd_pkg::STATUS_OK;
    n = num_len;
    while (n > 0 && num_coef[n-1] == 8'h00) n--;
    m = den_len;
    while (m > 0 && den_coef[m-1] == 8'h00) m--;
    if (n == 0) begin
      add_coef(gfpd_pkg::WHICH_REM, 0, 8'h00, st);
      add_coef(gfpd_pkg::WHICH_QUOT, 0, 8'h00, st);
    end else if (m == 0) begin
      add_coef(gfpd_pkg::WHICH_REM, 0, 8'h00, gfpd_pkg::STATUS_DIV_ZERO);
    end else if (m > n) begin
      for (int i = 0; i < n; i++) add_coef(gfpd_pkg::WHICH_REM, i, num_coef[i], st);
      add_coef(gfpd_pkg::WHICH_QUOT, 0, 8'h00, st);
    end else begin
      for (int i = 0; i < TERMS; i++) begin
        rem[i] = (i < n) ? num_coef[i] : 8'h00;
        quo[i] = 8'h00;
      end
      inv = gf_inv(den_coef[m-1]);
      for (int k = n; k >= m; k--) begin
        t = gf_mul(rem[k-1], inv);
        quo[k-m] = t;
        for (int j = 0; j < m; j++) rem[k-m+j] ^= gf_mul(t, den_coef[j]);
        rem[k-1] = 8'h00;
      end
      rl = m - 1;
      while (rl > 0 && rem[rl-1] == 8'h00) rl--;
      ql = n - m + 1;
      while (ql > 0 && quo[ql-1] == 8'h00) ql--;
      if (rl == 0) add_coef(gfpd_pkg::WHICH_REM, 0, 8'h00, st);
      for (int i = 0; i < rl; i++) add_coef(gfpd_pkg::WHICH_REM, i, rem[i], st);
      if (ql == 0) add_coef(gfpd_pkg::WHICH_QUOT, 0, 8'h00, st);
      for (int i = 0; i < ql; i++) add_coef(gfpd_pkg::WHICH_QUOT, i, quo[i], st);
    end
    expected_beats[expected_beats.size() - 1].last = 1'b1;
    num_len = 0;
    den_len = 0;
    ovf = 1'b0;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_beats[0];
        predict_division(pending_beats.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver readiness, with an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_hold <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      recv_hold <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        gfpd_pkg::out_beat_t exp_b;
        exp_b = expected_beats.pop_front();
        if (out_data !== exp_b) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_b, out_data);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic queue_beat(logic [1:0] cmd, logic [7:0] c);
    gfpd_pkg::in_beat_t b;
    b.command = cmd;
    b.coefficient = c;
    pending_beats = {pending_beats, b};
  endtask

  task automatic queue_problem(int nlen, int dlen, bit zero_tops);
    for (int i = 0; i < nlen; i++)
      queue_beat(gfpd_pkg::CMD_LOAD_DIVIDEND,
                 (zero_tops && i == nlen - 1) ? 8'h00 : 8'($urandom_range(255)));
    for (int i = 0; i < dlen; i++)
      queue_beat(gfpd_pkg::CMD_LOAD_DIVISOR,
                 (zero_tops && i == dlen - 1) ? 8'h00 : 8'($urandom_range(255)));
    queue_beat(gfpd_pkg::CMD_COMPUTE, 8'($urandom_range(255)));
  endtask

  task automatic drain();
    while (pending_beats.size() > 0 || expected_beats.size() > 0 || in_valid)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_field(logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    field_low = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int items);
    int sent;
    int r;
    sent = 0;
    while (sent < items) begin
      r = $urandom_range(99);
      if (r < 80) begin
        int nl, dl;
        nl = ($urandom_range(9) == 0) ? $urandom_range(33) : $urandom_range(8);
        dl = ($urandom_range(9) == 0) ? $urandom_range(33) : $urandom_range(1, 5);
        queue_problem(nl, dl, $urandom_range(3) == 0);
        sent += nl + dl + 1;
      end else begin
        queue_beat(2'($urandom_range(3)), 8'($urandom_range(255)));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = 8'h00;
    field_low = 8'h1b;
    num_len = 0;
    den_len = 0;
    ovf = 1'b0;
    send_idle_pct = 15;
    recv_idle_pct = 71;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty dividend, zero divisor, higher-degree divisor, extremes
    queue_beat(gfpd_pkg::CMD_COMPUTE, 8'h00);
    queue_beat(gfpd_pkg::CMD_LOAD_DIVIDEND, 8'hff);
    queue_beat(gfpd_pkg::CMD_LOAD_DIVISOR, 8'h00);
    queue_beat(gfpd_pkg::CMD_COMPUTE, 8'hff);
    queue_beat(gfpd_pkg::CMD_LOAD_DIVIDEND, 8'h01);
    queue_beat(gfpd_pkg::CMD_LOAD_DIVISOR, 8'h02);
    queue_beat(gfpd_pkg::CMD_LOAD_DIVISOR, 8'h80);
    queue_beat(gfpd_pkg::CMD_COMPUTE, 8'h00);
    queue_beat(CMD_UNUSED, 8'h55);
    queue_problem(4, 2, 1'b0);
    queue_problem(3, 3, 1'b1);
    drain();

    // overflow on both stores with the receiver held off; more loads wait behind
    hold_reqs++;
    queue_problem(33, 33, 1'b0);
    queue_problem(4, 2, 1'b0);
    drain();

    write_field(8'h00);
    queue_problem(5, 2, 1'b0);
    drain();
    write_field(8'hff);
    queue_problem(5, 3, 1'b0);
    drain();
    write_field(8'h1d);

    random_phase(60);
    drain();
    send_idle_pct = 71;
    recv_idle_pct = 15;
    write_field(8'h4d);
    random_phase(55);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_field(8'h1b);
    random_phase(55);
    drain();

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
